FILE: hdl/awb_gain_normalizer_core_assert.svh
// Assertion macros for the gain normaliser
`ifndef AWB_GAIN_NORMALIZER_CORE_ASSERT_SVH
`define AWB_GAIN_NORMALIZER_CORE_ASSERT_SVH
`ifndef SYNTH
`define AWB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AWB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AWB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AWB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/awb_pkg.sv
package awb_pkg;
    localparam int unsigned DATA_W    = 16;
    localparam int unsigned NUM_W     = 26;
    localparam int unsigned QUO_W     = 26;
    localparam int unsigned DIV_STEPS = 26;
    localparam logic [15:0] UNITY_GAIN = 16'h0100;
    localparam logic [15:0] RATIO_ONE  = 16'd512;

    // register byte addresses
    localparam logic [2:0] REG_GOLDEN_RG = 3'd0;
    localparam logic [2:0] REG_GOLDEN_BG = 3'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_IN   = 2'd1,
        ST_ZERO_RAT  = 2'd2
    } status_t;

    // one divider lane: partial remainder, numerator bits and quotient
    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [DATA_W-1:0] den;
        logic [QUO_W-1:0]  quo;
        logic [DATA_W:0]   rem;
    } div_lane_t;
endpackage

FILE: hdl/awb_div_pipe.sv
// Restoring divider, one quotient bit per stage, with stall support.
// Carries a side-band tag alongside the lanes.
module awb_div_pipe
    import awb_pkg::*;
#(
    parameter int unsigned LANES = 2,
    parameter int unsigned TAG_W = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]   in_num,
    input  logic [LANES-1:0][DATA_W-1:0]  in_den,
    input  logic [TAG_W-1:0]              in_tag,
    output logic                          out_valid,
    output logic [LANES-1:0][QUO_W-1:0]   out_quo,
    output logic [TAG_W-1:0]              out_tag
);
    div_lane_t [LANES-1:0]   lane_reg [DIV_STEPS];
    div_lane_t [LANES-1:0]   lane_next [DIV_STEPS];
    logic [TAG_W-1:0]        tag_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0]    vld_reg;

    // one shift-subtract step per stage
    always_comb
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                div_lane_t   src;
                logic [DATA_W:0] trial;
                logic [DATA_W+1:0] diff;
                if (s == 0)
                begin
                    src.num = in_num[l];
                    src.den = in_den[l];
                    src.quo = '0;
                    src.rem = '0;
                end
                else
                begin
                    src = lane_reg[s-1][l];
                end
                trial = {src.rem[DATA_W-1:0], src.num[NUM_W-1]};
                diff  = {1'b0, trial} - {2'b00, src.den};
                lane_next[s][l].num = {src.num[NUM_W-2:0], 1'b0};
                lane_next[s][l].den = src.den;
                if (!diff[DATA_W+1])
                begin
                    lane_next[s][l].rem = diff[DATA_W:0];
                    lane_next[s][l].quo = {src.quo[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    lane_next[s][l].rem = trial;
                    lane_next[s][l].quo = {src.quo[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
                lane_reg[s] <= lane_next[s];
            tag_reg[0] <= in_tag;
            for (int s = 1; s < DIV_STEPS; s++)
                tag_reg[s] <= tag_reg[s-1];
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_tag   = tag_reg[DIV_STEPS-1];
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            out_quo[l] = lane_reg[DIV_STEPS-1][l].quo;
    end
endmodule

FILE: hdl/awb_gain_normalizer_core.sv
// An input transaction reaches the result through two 26-stage divider pipelines in series
// and an output register; back-pressure holds it in place.
// Throughput: one transaction per cycle; the pipeline moves whenever its output
// register is empty or being taken.
// Reset: rst_n asynchronous, active low; clears valid bits and golden ratios.
module awb_gain_normalizer_core
    import awb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] measured_rg,
    input  logic [15:0] measured_bg,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] red_gain,
    output logic [15:0] green_gain,
    output logic [15:0] blue_gain
);
`include "awb_gain_normalizer_core_assert.svh"

    localparam int unsigned TAG1_W = 1;
    localparam int unsigned TAG2_W = 5;

    logic [15:0] golden_rg_reg;
    logic [15:0] golden_bg_reg;
    logic        advance;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            golden_rg_reg <= '0;
            golden_bg_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                REG_GOLDEN_RG: golden_rg_reg <= pwdata[15:0];
                REG_GOLDEN_BG: golden_bg_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_GOLDEN_RG: prdata = {16'h0000, golden_rg_reg};
            REG_GOLDEN_BG: prdata = {16'h0000, golden_bg_reg};
            default:       prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // first division: correction ratios
    logic                        zero_in;
    logic [1:0][NUM_W-1:0]       d1_num;
    logic [1:0][DATA_W-1:0]      d1_den;
    logic                        d1_valid;
    logic [1:0][QUO_W-1:0]       d1_quo;
    logic [TAG1_W-1:0]           d1_tag;

    assign zero_in = (measured_rg == '0) || (measured_bg == '0)
                  || (golden_rg_reg == '0) || (golden_bg_reg == '0);
    assign d1_num[0] = {1'b0, golden_rg_reg, 9'd0};
    assign d1_num[1] = {1'b0, golden_bg_reg, 9'd0};
    assign d1_den[0] = zero_in ? 16'd1 : measured_rg;
    assign d1_den[1] = zero_in ? 16'd1 : measured_bg;

    awb_div_pipe #(.LANES(2), .TAG_W(TAG1_W)) u_div_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid && in_ready),
        .in_num   (d1_num),
        .in_den   (d1_den),
        .in_tag   (zero_in),
        .out_valid(d1_valid),
        .out_quo  (d1_quo),
        .out_tag  (d1_tag)
    );

    // second division: case select between ratios
    logic [15:0]            rr;
    logic [15:0]            br;
    logic                   rr_big;
    logic                   br_big;
    logic [1:0][NUM_W-1:0]  d2_num;
    logic [1:0][DATA_W-1:0] d2_den;
    logic [TAG2_W-1:0]      d2_tag_in;
    logic                   d2_valid;
    logic [1:0][QUO_W-1:0]  d2_quo;
    logic [TAG2_W-1:0]      d2_tag;
    logic                   zero_rat;

    assign rr = d1_quo[0][15:0];
    assign br = d1_quo[1][15:0];
    assign rr_big = rr >= RATIO_ONE;
    assign br_big = br >= RATIO_ONE;
    assign zero_rat = (rr == '0) || (br == '0);

    // lane 0: 256*br/rr; lane 1: 256*rr/br
    always_comb
    begin
        d2_num[0] = {16'd0, 1'b0, 9'd0};
        d2_num[1] = {16'd0, 1'b0, 9'd0};
        d2_num[0] = {2'b00, br, 8'd0};
        d2_num[1] = {2'b00, rr, 8'd0};
        d2_den[0] = (rr == '0) ? 16'd1 : rr;
        d2_den[1] = (br == '0) ? 16'd1 : br;
    end
    // green quotients need their own lanes
    logic [1:0][NUM_W-1:0]  g_num;
    logic [1:0][QUO_W-1:0]  g_quo;
    logic                   g_valid;
    logic [TAG2_W-1:0]      g_tag;
    assign g_num[0] = NUM_W'(26'd131072);
    assign g_num[1] = NUM_W'(26'd131072);

    assign d2_tag_in = {d1_tag[0], zero_rat, rr_big, br_big, 1'b0};

    awb_div_pipe #(.LANES(2), .TAG_W(TAG2_W)) u_div_gain (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (d1_valid),
        .in_num   (d2_num),
        .in_den   (d2_den),
        .in_tag   (d2_tag_in),
        .out_valid(d2_valid),
        .out_quo  (d2_quo),
        .out_tag  (d2_tag)
    );

    awb_div_pipe #(.LANES(2), .TAG_W(TAG2_W)) u_div_green (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (d1_valid),
        .in_num   (g_num),
        .in_den   (d2_den),
        .in_tag   (d2_tag_in),
        .out_valid(g_valid),
        .out_quo  (g_quo),
        .out_tag  (g_tag)
    );

    // ratios themselves for the both-big case, carried alongside
    logic [15:0] rr_dly_reg [DIV_STEPS];
    logic [15:0] br_dly_reg [DIV_STEPS];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rr_dly_reg[0] <= rr;
            br_dly_reg[0] <= br;
            for (int s = 1; s < DIV_STEPS; s++)
            begin
                rr_dly_reg[s] <= rr_dly_reg[s-1];
                br_dly_reg[s] <= br_dly_reg[s-1];
            end
        end
    end

    // gain selection
    logic [1:0]  status_next;
    logic [15:0] red_next;
    logic [15:0] green_next;
    logic [15:0] blue_next;
    logic [15:0] gr;
    logic [15:0] gb;
    logic [15:0] rr_d;
    logic [15:0] br_d;

    assign gr   = g_quo[0][15:0];
    assign gb   = g_quo[1][15:0];
    assign rr_d = rr_dly_reg[DIV_STEPS-1];
    assign br_d = br_dly_reg[DIV_STEPS-1];

    always_comb
    begin
        status_next = ST_OK;
        red_next    = '0;
        green_next  = '0;
        blue_next   = '0;
        if (d2_tag[4])
            status_next = ST_ZERO_IN;
        else if (d2_tag[3])
            status_next = ST_ZERO_RAT;
        else if (d2_tag[2] && d2_tag[1])
        begin
            red_next   = {1'b0, rr_d[15:1]};
            green_next = UNITY_GAIN;
            blue_next  = {1'b0, br_d[15:1]};
        end
        else if (d2_tag[2])
        begin
            red_next   = d2_quo[1][15:0];
            green_next = gb;
            blue_next  = UNITY_GAIN;
        end
        else if (d2_tag[1] || (gr >= gb))
        begin
            red_next   = UNITY_GAIN;
            green_next = gr;
            blue_next  = d2_quo[0][15:0];
        end
        else
        begin
            red_next   = d2_quo[1][15:0];
            green_next = gb;
            blue_next  = UNITY_GAIN;
        end
    end

    // output register
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [15:0] red_reg;
    logic [15:0] green_reg;
    logic [15:0] blue_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && d2_valid)
        begin
            status_reg <= status_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign red_gain   = red_reg;
    assign green_gain = green_reg;
    assign blue_gain  = blue_reg;

    // checks
    `AWB_ASSERT_IMPL(a_lanes_agree, clk, rst_n, 1'b1, d2_valid == g_valid)
    `AWB_ASSERT_IMPL(a_tags_agree, clk, rst_n, d2_valid, g_tag == d2_tag)
    `AWB_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_valid_reg && !out_ready,
        out_valid_reg && $stable(red_reg))
    `AWB_ASSERT_IMPL(a_error_zero, clk, rst_n, out_valid_reg && (status_reg != ST_OK),
        (red_reg == '0) && (green_reg == '0) && (blue_reg == '0))
endmodule
